// ===== hw/rtl/lprl_pkg.sv =====
// ----------------------------------------------------------------------------
// lprl_pkg: shared types and constants of the route lookup engine
// Field widths, function codes and the request carried from front to back.
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned PLEN_W  = 6;

  // Function codes of an input transaction
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Classified request queued between front and back
  typedef struct packed {
    logic               lookup;    // 1: search the table, 0: write an entry
    logic               wr_legal;  // write slot and port both in range
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  key;       // destination on a write, address on a lookup
    logic [ADDR_W-1:0]  mask;
    logic [PORT_W-1:0]  port;
    logic               enable;
  } req_t;

endpackage

// ===== hw/rtl/longest_prefix_route_lookup.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup: longest-prefix IPv4 route lookup engine
// Routing table of TABLE_ENTRIES routes with write and lookup transactions.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in_     | input     | in_valid / in_ready  | func, entry_*, lookup_addr
//   out_    | output    | out_valid / out_ready| was_lookup, hit, match_*, len
//
// A write transaction finishes in the back end when it is taken; a lookup runs
// a scan that reads one table entry per cycle through the registered read
// port of the table memory, then passes through ST_TAIL and ST_RES.
// The front queue registers each transaction and keeps accepting transactions
// (two deep) while the back end scans or the output register waits.
// Reset is synchronous, active low; it empties the queue and clears every
// route valid bit at once, so the block is ready in the first cycle after.
//
module longest_prefix_route_lookup #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PORT_COUNT    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [lprl_pkg::INDEX_W-1:0]      in_entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_entry_dest,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_entry_mask,
  input  logic [lprl_pkg::PORT_W-1:0]       in_entry_port,
  input  logic                              in_entry_enable,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_lookup_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_was_lookup,
  output logic                              out_hit,
  output logic [lprl_pkg::INDEX_W-1:0]      out_match_index,
  output logic [lprl_pkg::PORT_W-1:0]       out_match_port,
  output logic [lprl_pkg::PLEN_W-1:0]       out_prefix_len
);

  // Queue interface between front and back
  logic           q_valid;
  logic           q_pop;
  lprl_pkg::req_t q_item;

  // Front: accept, classify and queue transactions
  lprl_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_dest   (in_entry_dest),
    .in_entry_mask   (in_entry_mask),
    .in_entry_port   (in_entry_port),
    .in_entry_enable (in_entry_enable),
    .in_lookup_addr  (in_lookup_addr),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back: hold the table, execute writes, scan on lookups, drive results
  lprl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_was_lookup  (out_was_lookup),
    .out_hit         (out_hit),
    .out_match_index (out_match_index),
    .out_match_port  (out_match_port),
    .out_prefix_len  (out_prefix_len)
  );

endmodule

// ===== hw/rtl/lprl_front.sv =====
// ----------------------------------------------------------------------------
// lprl_front: input stage of the route lookup engine
// Accepts transactions, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lprl_front #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PORT_COUNT    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [lprl_pkg::INDEX_W-1:0]      in_entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_entry_dest,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_entry_mask,
  input  logic [lprl_pkg::PORT_W-1:0]       in_entry_port,
  input  logic                              in_entry_enable,
  input  logic [lprl_pkg::ADDR_W-1:0]       in_lookup_addr,
  output logic                              q_valid,
  output lprl_pkg::req_t                    q_item,
  input  logic                              q_pop
);

  lprl_pkg::req_t item;
  lprl_pkg::req_t q_mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           push;

  // Classify: pick the key and check write legality up front
  always_comb begin
    item          = '0;
    item.lookup   = (in_func == lprl_pkg::FUNC_LOOKUP);
    item.wr_legal = (32'(in_entry_index) < TABLE_ENTRIES) &&
                    (32'(in_entry_port) < PORT_COUNT);
    item.index    = in_entry_index;
    item.key      = item.lookup ? in_lookup_addr : in_entry_dest;
    item.mask     = in_entry_mask;
    item.port     = in_entry_port;
    item.enable   = in_entry_enable;
  end

  assign in_ready  = (count_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];
  assign count_nxt = count_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/lprl_back.sv =====
// ----------------------------------------------------------------------------
// lprl_back: table and search engine of the route lookup engine
// Executes writes and scans the route table one entry per cycle on lookups.
// ----------------------------------------------------------------------------
module lprl_back #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  lprl_pkg::req_t                    q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_was_lookup,
  output logic                              out_hit,
  output logic [lprl_pkg::INDEX_W-1:0]      out_match_index,
  output logic [lprl_pkg::PORT_W-1:0]       out_match_port,
  output logic [lprl_pkg::PLEN_W-1:0]       out_prefix_len
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_RES  = 4'b1000
  } state_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b0, v[i]};
    end
    return n;
  endfunction

  state_t state_r;
  state_t state_nxt;

  logic [lprl_pkg::ADDR_W-1:0] dest_mem [TABLE_ENTRIES];
  logic [lprl_pkg::ADDR_W-1:0] mask_mem [TABLE_ENTRIES];
  logic [lprl_pkg::PORT_W-1:0] port_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    valid_r;

  logic [IDX_W-1:0]            rd_idx_r;
  logic [lprl_pkg::ADDR_W-1:0] key_r;
  logic [lprl_pkg::ADDR_W-1:0] rd_dest_r;
  logic [lprl_pkg::ADDR_W-1:0] rd_mask_r;
  logic [lprl_pkg::PORT_W-1:0] rd_port_r;
  logic                        rd_valid_r;
  logic                        cmp_vld_r;
  logic [IDX_W-1:0]            cmp_idx_r;

  logic                        best_found_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic [lprl_pkg::ADDR_W-1:0] best_mask_r;
  logic [lprl_pkg::PORT_W-1:0] best_port_r;

  logic                        out_valid_r;
  logic                        out_was_lookup_r;
  logic                        out_hit_r;
  logic [lprl_pkg::INDEX_W-1:0] out_match_index_r;
  logic [lprl_pkg::PORT_W-1:0] out_match_port_r;
  logic [lprl_pkg::PLEN_W-1:0] out_prefix_len_r;

  logic                        out_free;
  logic                        take;
  logic                        mem_we;
  logic [IDX_W-1:0]            wr_addr;
  logic                        entry_match;
  logic                        load_ack;
  logic                        load_res;
  logic [lprl_pkg::PLEN_W-1:0] best_len;

  assign out_free    = !out_valid_r || out_ready;
  assign take        = (state_r == ST_IDLE) && q_valid && out_free;
  assign q_pop       = take;
  assign mem_we      = take && !q_item.lookup && q_item.wr_legal;
  assign wr_addr     = IDX_W'(q_item.index);
  assign load_ack    = take && !q_item.lookup;
  assign load_res    = (state_r == ST_RES) && out_free;

  // Hit on this entry if valid, masked equal and no shorter than the best so far
  assign entry_match = cmp_vld_r && rd_valid_r &&
                       (((rd_dest_r ^ key_r) & rd_mask_r) == '0) &&
                       (!best_found_r || (best_mask_r <= rd_mask_r));

  assign best_len = lprl_pkg::PLEN_W'(ones8(best_mask_r[7:0]))   +
                    lprl_pkg::PLEN_W'(ones8(best_mask_r[15:8]))  +
                    lprl_pkg::PLEN_W'(ones8(best_mask_r[23:16])) +
                    lprl_pkg::PLEN_W'(ones8(best_mask_r[31:24]));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && q_item.lookup) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: state_nxt = ST_RES;
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Table storage and its registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dest_mem[wr_addr] <= q_item.key;
      mask_mem[wr_addr] <= q_item.mask;
      port_mem[wr_addr] <= q_item.port;
    end
    rd_dest_r  <= dest_mem[rd_idx_r];
    rd_mask_r  <= mask_mem[rd_idx_r];
    rd_port_r  <= port_mem[rd_idx_r];
    rd_valid_r <= valid_r[rd_idx_r];
    cmp_idx_r  <= rd_idx_r;
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= q_item.key;
    end
    if (entry_match) begin
      best_idx_r  <= cmp_idx_r;
      best_mask_r <= rd_mask_r;
      best_port_r <= rd_port_r;
    end
    if (load_ack) begin
      out_was_lookup_r  <= 1'b0;
      out_hit_r         <= 1'b0;
      out_match_index_r <= '0;
      out_match_port_r  <= '0;
      out_prefix_len_r  <= '0;
    end else if (load_res) begin
      out_was_lookup_r  <= 1'b1;
      out_hit_r         <= best_found_r;
      out_match_index_r <= best_found_r ? lprl_pkg::INDEX_W'(best_idx_r) : '0;
      out_match_port_r  <= best_found_r ? best_port_r : '0;
      out_prefix_len_r  <= best_found_r ? best_len : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (mem_we) begin
        valid_r[wr_addr] <= q_item.enable;
      end
      if (state_r == ST_SCAN) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end else begin
        rd_idx_r <= '0;
      end
      if (take) begin
        best_found_r <= 1'b0;
      end else if (entry_match) begin
        best_found_r <= 1'b1;
      end
      if (load_ack || load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_lookup  = out_was_lookup_r;
  assign out_hit         = out_hit_r;
  assign out_match_index = out_match_index_r;
  assign out_match_port  = out_match_port_r;
  assign out_prefix_len  = out_prefix_len_r;

endmodule
